[design/met_pkg.sv]
// Shared constants for the Mandelbrot escape-time block.
package met_pkg;

	localparam int FRAC_BITS  = 28;
	localparam int COORD_W    = 36;
	localparam int ITER_W     = 16;
	localparam int RADIUS_W   = 3;
	localparam int INDEX_W    = 10;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int DATA_W     = 64;
	localparam int ADDR_W     = 6;
	localparam int REG_IDX_W  = 3;
	localparam int IDX_CMP_W  = 13;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [REG_IDX_W-1:0] REG_X_START    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_X_STEP     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_Y_START    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_Y_STEP     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS     = 3'd5;

	localparam logic signed [COORD_W-1:0] RST_X_START = -36'sd536870912;
	localparam logic signed [COORD_W-1:0] RST_X_STEP  = 36'sd612032;
	localparam logic signed [COORD_W-1:0] RST_Y_START = -36'sd332859965;
	localparam logic signed [COORD_W-1:0] RST_Y_STEP  = 36'sd665720;
	localparam logic [ITER_W-1:0]         RST_ITER_LIMIT = 16'd100;
	localparam logic [RADIUS_W-1:0]       RST_RADIUS     = 3'd2;

endpackage

[design/mandelbrot_escape_time_top.sv]
// Top level of the Mandelbrot escape-time pixel evaluator.
//
// Input channel (in_valid/in_ready) takes one pixel item: col_index, row_index.
// Indices at or above MAX_WIDTH / MAX_HEIGHT clamp to the last column / row.
// The point c = start + index * step is formed, then z = z^2 + c is iterated
// from zero until the count reaches the iteration limit or |z|^2 reaches radius^2.
// Output channel (out_valid/out_ready) gives iteration_count and in_set.
// Registers sit on an APB port at byte address 8*i, 64-bit data, pready tied
// high; write them only while no item is in flight.
// After acceptance the point c is formed; then the limit or the per-axis
// magnitude test ends the loop before the multiply, and the squared-sum test
// after it. Each iteration passes first through the three 32x32 multipliers
// (squares and cross product), then through the shift, add and exact escape
// compare. One item is in work at a time; in_ready is high only while the
// sequencer is idle, so the next item is taken at the earliest in the cycle
// after its predecessor's result is loaded.
// A finished result waits in the output register while the receiver stalls;
// the next item may be accepted meanwhile, and its result waits until the
// register is taken.
// Reset loads the default view registers and empties the block.
module mandelbrot_escape_time_top #(
	parameter int MAX_WIDTH  = met_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = met_pkg::DEF_MAX_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [met_pkg::ADDR_W-1:0]        paddr,
	input  logic [met_pkg::DATA_W-1:0]        pwdata,
	output logic [met_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [met_pkg::INDEX_W-1:0]       col_index,
	input  logic [met_pkg::INDEX_W-1:0]       row_index,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [met_pkg::ITER_W-1:0]        iteration_count,
	output logic                              in_set
);

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int IW  = (CW > RW) ? CW : RW;
	localparam int CXW = met_pkg::COORD_W + IW + 2;
	localparam int ZW  = CXW + 1;
	localparam int MW  = met_pkg::MUL_W;
	localparam int PW  = met_pkg::PROD_W;
	localparam int FB  = met_pkg::FRAC_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COORD,
		ST_CHECK,
		ST_MULT,
		ST_RESULT
	} state_t;

	state_t state_q;

	logic signed [met_pkg::COORD_W-1:0]  x_start_q, x_step_q, y_start_q, y_step_q;
	logic [met_pkg::ITER_W-1:0]          iter_limit_q;
	logic [met_pkg::RADIUS_W-1:0]        radius_q;

	logic [CW-1:0]          col_q;
	logic [RW-1:0]          row_q;
	logic [CW-1:0]          col_sat;
	logic [RW-1:0]          row_sat;
	logic signed [CXW-1:0]  cx_q, cy_q, cx_next, cy_next;
	logic signed [ZW-1:0]   zx_q, zy_q, zx_next, zy_next;
	logic signed [PW-1:0]   sxx_q, syy_q, sxy_q, sdiff;
	logic [met_pkg::ITER_W-1:0] iter_q;

	logic                   cfg_wr;
	logic [met_pkg::REG_IDX_W-1:0] cfg_idx;
	logic signed [ZW-1:0]   rlim;
	logic [PW-1:0]          r2, mag_sum;
	logic                   esc_mag, esc_sum, limit_hit;
	logic signed [MW-1:0]   zx_m, zy_m;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[met_pkg::ADDR_W-1 -: met_pkg::REG_IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q    <= met_pkg::RST_X_START;
			x_step_q     <= met_pkg::RST_X_STEP;
			y_start_q    <= met_pkg::RST_Y_START;
			y_step_q     <= met_pkg::RST_Y_STEP;
			iter_limit_q <= met_pkg::RST_ITER_LIMIT;
			radius_q     <= met_pkg::RST_RADIUS;
		end else if (cfg_wr) begin
			case (cfg_idx)
				met_pkg::REG_X_START:    x_start_q    <= pwdata[met_pkg::COORD_W-1:0];
				met_pkg::REG_X_STEP:     x_step_q     <= pwdata[met_pkg::COORD_W-1:0];
				met_pkg::REG_Y_START:    y_start_q    <= pwdata[met_pkg::COORD_W-1:0];
				met_pkg::REG_Y_STEP:     y_step_q     <= pwdata[met_pkg::COORD_W-1:0];
				met_pkg::REG_ITER_LIMIT: iter_limit_q <= pwdata[met_pkg::ITER_W-1:0];
				met_pkg::REG_RADIUS:     radius_q     <= pwdata[met_pkg::RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			met_pkg::REG_X_START:    prdata = met_pkg::DATA_W'($unsigned(x_start_q));
			met_pkg::REG_X_STEP:     prdata = met_pkg::DATA_W'($unsigned(x_step_q));
			met_pkg::REG_Y_START:    prdata = met_pkg::DATA_W'($unsigned(y_start_q));
			met_pkg::REG_Y_STEP:     prdata = met_pkg::DATA_W'($unsigned(y_step_q));
			met_pkg::REG_ITER_LIMIT: prdata = met_pkg::DATA_W'(iter_limit_q);
			met_pkg::REG_RADIUS:     prdata = met_pkg::DATA_W'(radius_q);
			default:                 prdata = '0;
		endcase
	end

	// clamp indices to the image
	always_comb begin
		if (met_pkg::IDX_CMP_W'(col_index) > met_pkg::IDX_CMP_W'(MAX_WIDTH - 1))
			col_sat = CW'(MAX_WIDTH - 1);
		else
			col_sat = CW'(col_index);
		if (met_pkg::IDX_CMP_W'(row_index) > met_pkg::IDX_CMP_W'(MAX_HEIGHT - 1))
			row_sat = RW'(MAX_HEIGHT - 1);
		else
			row_sat = RW'(row_index);
	end

	// datapath arithmetic
	assign cx_next = CXW'(x_start_q) + CXW'(x_step_q * $signed({1'b0, col_q}));
	assign cy_next = CXW'(y_start_q) + CXW'(y_step_q * $signed({1'b0, row_q}));

	assign zx_m = zx_q[MW-1:0];
	assign zy_m = zy_q[MW-1:0];

	assign rlim      = $signed(ZW'({radius_q, FB'(0)}));
	assign esc_mag   = (zx_q >= rlim) || (zx_q <= -rlim) ||
	                   (zy_q >= rlim) || (zy_q <= -rlim);
	assign limit_hit = (iter_q >= iter_limit_q);

	assign r2      = PW'(radius_q * radius_q) << (2 * FB);
	assign mag_sum = $unsigned(sxx_q) + $unsigned(syy_q);
	assign esc_sum = (mag_sum >= r2);

	assign sdiff   = sxx_q - syy_q;
	assign zx_next = ZW'(sdiff >>> FB) + ZW'(cx_q);
	assign zy_next = ZW'(sxy_q >>> (FB - 1)) + ZW'(cy_q);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					col_q <= col_sat;
					row_q <= row_sat;
				end
			end
			ST_COORD: begin
				cx_q <= cx_next;
				cy_q <= cy_next;
				zx_q <= '0;
				zy_q <= '0;
			end
			ST_CHECK: begin
				sxx_q <= zx_m * zx_m;
				syy_q <= zy_m * zy_m;
				sxy_q <= zx_m * zy_m;
			end
			ST_MULT: begin
				zx_q <= zx_next;
				zy_q <= zy_next;
			end
			default: ;
		endcase
	end

	// sequencer and output register
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			iter_q          <= '0;
			out_valid       <= 1'b0;
			iteration_count <= '0;
			in_set          <= 1'b0;
		end else begin
			if (out_valid && out_ready && (state_q != ST_RESULT))
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_COORD;
				end
				ST_COORD: begin
					iter_q  <= '0;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (limit_hit || esc_mag)
						state_q <= ST_RESULT;
					else
						state_q <= ST_MULT;
				end
				ST_MULT: begin
					if (esc_sum) begin
						state_q <= ST_RESULT;
					end else begin
						iter_q  <= iter_q + 1'b1;
						state_q <= ST_CHECK;
					end
				end
				ST_RESULT: begin
					if (!out_valid || out_ready) begin
						out_valid       <= 1'b1;
						iteration_count <= iter_q;
						in_set          <= (iter_q == iter_limit_q);
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("block still ready after taking an item");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT) && !out_valid |=> out_valid && in_ready)
		else $error("finished result not loaded into the output register");

	a_result_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (state_q != ST_RESULT) |=> !out_valid)
		else $error("taken result still shown");

	a_mult_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULT) |=> (state_q == ST_CHECK) || (state_q == ST_RESULT))
		else $error("iteration step left the loop unexpectedly");

endmodule
